// File: rtl/core/nbe_pkg.sv
package nbe_pkg;

   // field widths
   localparam int ByteWidth  = 8;
   localparam int RadixWidth = 5;
   localparam int TableWidth = 64;
   localparam int DigitWidth = 4;
   localparam int NumDigits  = 8;
   localparam int WidthBits  = 4;
   localparam int RecipWidth = 16;
   localparam int CsrIdxWidth = 2;

   // register indexes
   localparam logic [CsrIdxWidth-1:0] CsrRadix     = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CsrDigitsLow = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CsrDigitsHigh = 2'd2;

   // reset values
   localparam logic [RadixWidth-1:0] RadixReset      = 5'd16;
   localparam logic [TableWidth-1:0] DigitsLowReset  = 64'h3736353433323130;
   localparam logic [TableWidth-1:0] DigitsHighReset = 64'h6665646362613938;

   // characters and printable range
   localparam logic [ByteWidth-1:0] EscChar       = 8'd92;
   localparam logic [ByteWidth-1:0] PrintableLow  = 8'd32;
   localparam logic [ByteWidth-1:0] PrintableHigh = 8'd126;

   typedef struct packed {
      logic [ByteWidth-1:0] byte_in;
      logic                 last_in;
   } req_type;

   typedef struct packed {
      logic [ByteWidth-1:0] char_out;
      logic                 last_out;
   } rsp_type;

   // one classified item with its digits, least significant digit first
   typedef struct packed {
      logic                                esc;
      logic [ByteWidth-1:0]                chr;
      logic                                last;
      logic [WidthBits-1:0]                width;
      logic [NumDigits-1:0][DigitWidth-1:0] digits;
   } item_type;

   // clamp the radix register to 2..16
   function automatic logic [RadixWidth-1:0] eff_radix(input logic [RadixWidth-1:0] r);
      logic [RadixWidth-1:0] res;
      res = r;
      if (r < 5'd2) begin
         res = 5'd2;
      end else if (r > 5'd16) begin
         res = 5'd16;
      end
      return res;
   endfunction

   // ceil(2^16 / r): exact quotient for 8-bit values via (v * m) >> 16
   function automatic logic [RecipWidth-1:0] recip(input logic [RadixWidth-1:0] r);
      logic [RecipWidth-1:0] m;
      case (r)
         5'd2:    m = 16'd32768;
         5'd3:    m = 16'd21846;
         5'd4:    m = 16'd16384;
         5'd5:    m = 16'd13108;
         5'd6:    m = 16'd10923;
         5'd7:    m = 16'd9363;
         5'd8:    m = 16'd8192;
         5'd9:    m = 16'd7282;
         5'd10:   m = 16'd6554;
         5'd11:   m = 16'd5958;
         5'd12:   m = 16'd5462;
         5'd13:   m = 16'd5042;
         5'd14:   m = 16'd4682;
         5'd15:   m = 16'd4370;
         default: m = 16'd4096;
      endcase
      return m;
   endfunction

   // number of digits of 255 in radix r
   function automatic logic [WidthBits-1:0] pad_width(input logic [RadixWidth-1:0] r);
      logic [WidthBits-1:0] w;
      case (r)
         5'd2:                   w = 4'd8;
         5'd3:                   w = 4'd6;
         5'd4, 5'd5, 5'd6:       w = 4'd4;
         5'd16:                  w = 4'd2;
         default:                w = 4'd3;
      endcase
      return w;
   endfunction

endpackage

// File: rtl/core/nbe_front.sv
module nbe_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  nbe_pkg::req_type data,
   input  logic [4:0]       radix,
   output logic             q_push,
   output nbe_pkg::item_type q_item,
   input  logic             q_full
);
   import nbe_pkg::*;

   localparam int NumStages = NumDigits + 1;

   item_type             stg_ff [NumStages];
   item_type             stg_in [NumStages];
   logic [RadixWidth-1:0] q_cur_ff [NumStages];
   logic [RadixWidth-1:0] q_cur_in [NumStages];
   logic [ByteWidth-1:0] qv_ff [NumStages];
   logic [ByteWidth-1:0] qv_in [NumStages];
   logic [ByteWidth-1:0] qn_ff [NumStages];
   logic [ByteWidth-1:0] qn_in [NumStages];
   logic [NumStages-1:0] vld_ff;
   logic [NumStages-1:0] vld_in;

   logic [RadixWidth-1:0] r_eff;
   logic [RecipWidth-1:0] m_eff;
   logic [ByteWidth+RecipWidth-1:0] prod_in;
   logic [ByteWidth+RecipWidth-1:0] prod_q [NumStages];
   logic [ByteWidth+RadixWidth-1:0] prod_r [NumStages];
   logic [ByteWidth+RadixWidth-1:0] rem_d [NumStages];
   logic adv;
   logic accept;

   assign r_eff  = eff_radix(radix);
   assign m_eff  = recip(r_eff);
   assign adv    = !vld_ff[NumStages-1] || !q_full;
   assign full   = !adv;
   assign accept = push && adv;
   assign q_push = vld_ff[NumStages-1] && !q_full;
   assign q_item = stg_ff[NumStages-1];

   // entry: classify and take the first quotient
   assign prod_in = {{RecipWidth{1'b0}}, data.byte_in} * {{ByteWidth{1'b0}}, m_eff};

   // digit pipeline: stage k yields digit k-1 = q_(k-1) - q_k * r
   always_comb begin
      stg_in[0].esc    = !((data.byte_in >= PrintableLow) && (data.byte_in <= PrintableHigh));
      stg_in[0].chr    = data.byte_in;
      stg_in[0].last   = data.last_in;
      stg_in[0].width  = pad_width(r_eff);
      stg_in[0].digits = '0;
      qv_in[0]         = data.byte_in;
      qn_in[0]         = prod_in[ByteWidth+RecipWidth-1:RecipWidth];
      q_cur_in[0]      = r_eff;
      prod_q[0]        = '0;
      prod_r[0]        = '0;
      rem_d[0]         = '0;
      for (int k = 1; k < NumStages; k++) begin
         prod_r[k] = {{RadixWidth{1'b0}}, qn_ff[k-1]} * {{ByteWidth{1'b0}}, q_cur_ff[k-1]};
         rem_d[k]  = {{RadixWidth{1'b0}}, qv_ff[k-1]} - prod_r[k];
         prod_q[k] = {{RecipWidth{1'b0}}, qn_ff[k-1]} * {{ByteWidth{1'b0}}, m_eff};
         stg_in[k] = stg_ff[k-1];
         stg_in[k].digits[k-1] = rem_d[k][DigitWidth-1:0];
         qv_in[k]    = qn_ff[k-1];
         qn_in[k]    = prod_q[k][ByteWidth+RecipWidth-1:RecipWidth];
         q_cur_in[k] = q_cur_ff[k-1];
      end
   end

   assign vld_in = {vld_ff[NumStages-2:0], accept};

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (adv) begin
         stg_ff   <= stg_in;
         qv_ff    <= qv_in;
         qn_ff    <= qn_in;
         q_cur_ff <= q_cur_in;
      end
   end

endmodule

// File: rtl/core/nbe_queue.sv
module nbe_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  nbe_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output nbe_pkg::item_type head_item,
   output logic              empty
);
   import nbe_pkg::*;

   localparam int Depth   = 4;
   localparam int PtrBits = $clog2(Depth);

   item_type             slot_ff [Depth];
   logic [PtrBits-1:0]   wr_ff, wr_in;
   logic [PtrBits-1:0]   rd_ff, rd_in;
   logic [PtrBits:0]     cnt_ff, cnt_in;
   logic                 do_push;
   logic                 do_pop;

   assign full      = (cnt_ff == Depth[PtrBits:0]);
   assign empty     = (cnt_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign head_item = slot_ff[rd_ff];

   // pointer and count update
   always_comb begin
      wr_in  = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_item;
      end
   end

endmodule

// File: rtl/core/nbe_back.sv
module nbe_back (
   input  logic               clock,
   input  logic               reset,
   input  nbe_pkg::item_type  q_item,
   input  logic               q_empty,
   output logic               q_pop,
   input  logic [127:0]       digit_table,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output nbe_pkg::rsp_type   rsp_data
);
   import nbe_pkg::*;

   item_type              cur_ff, cur_in;
   logic                  cur_vld_ff, cur_vld_in;
   logic [WidthBits-1:0]  idx_ff, idx_in;
   logic                  out_vld_ff, out_vld_in;
   rsp_type               out_ff, out_in;

   logic [15:0][7:0]      table_chars;
   logic                  out_adv;
   logic                  final_char;
   logic                  load;
   logic [WidthBits-1:0]  dsel_full;
   logic [2:0]            dsel;
   logic [DigitWidth-1:0] digit;
   rsp_type               emit;

   assign table_chars = digit_table;
   assign out_adv     = !out_vld_ff || rsp_pop;
   assign final_char  = !cur_ff.esc || (idx_ff == cur_ff.width);
   assign load        = !cur_vld_ff || (out_adv && final_char);
   assign q_pop       = load && !q_empty;

   // pick the character for the current position, most significant digit first
   assign dsel_full = cur_ff.width - idx_ff;
   assign dsel      = dsel_full[2:0];
   assign digit     = cur_ff.digits[dsel];

   always_comb begin
      if (!cur_ff.esc) begin
         emit.char_out = cur_ff.chr;
         emit.last_out = cur_ff.last;
      end else if (idx_ff == '0) begin
         emit.char_out = EscChar;
         emit.last_out = 1'b0;
      end else begin
         emit.char_out = table_chars[digit];
         emit.last_out = final_char && cur_ff.last;
      end
   end

   // current item and position
   always_comb begin
      cur_in     = cur_ff;
      cur_vld_in = cur_vld_ff;
      idx_in     = idx_ff;
      if (load) begin
         cur_in     = q_item;
         cur_vld_in = !q_empty;
         idx_in     = '0;
      end else if (out_adv && cur_vld_ff) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   // output register
   always_comb begin
      out_vld_in = out_vld_ff;
      out_in     = out_ff;
      if (out_adv) begin
         out_vld_in = cur_vld_ff;
         out_in     = emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
         idx_ff     <= '0;
      end else begin
         cur_vld_ff <= cur_vld_in;
         out_vld_ff <= out_vld_in;
         idx_ff     <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      out_ff <= out_in;
   end

   assign rsp_empty = !out_vld_ff;
   assign rsp_data  = out_ff;

endmodule

// File: rtl/core/nonprintable_byte_escaper_core.sv
// Byte escaper: each input transaction carries one byte and a last flag. Bytes 32..126 leave
// as one character; every other byte leaves as a backslash and its value in the programmed
// radix (2..16, clamped), zero padded, most significant digit first, drawn from the digit
// table, 1 + (digits of 255 in the radix) characters in all: 9 for radix 2 down to 3 for
// radix 16. Input is taken every cycle while the front pipeline can drain into its
// four-entry queue; the serializer, one character per cycle while the output is popped, sets
// the sustained rate. An accepted byte passes the nine-stage digit pipeline, the queue and
// the current-item and output registers. Write the registers only while idle.
module nonprintable_byte_escaper_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  nbe_pkg::req_type    req_data,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output nbe_pkg::rsp_type    rsp_data,
   input  logic                csr_we,
   input  logic [1:0]          csr_index,
   input  logic [63:0]         csr_wdata
);
   import nbe_pkg::*;

   logic [RadixWidth-1:0] radix_ff;
   logic [TableWidth-1:0] dig_lo_ff;
   logic [TableWidth-1:0] dig_hi_ff;

   logic     q_push;
   logic     q_full;
   logic     q_pop;
   logic     q_empty;
   item_type q_in_item;
   item_type q_head;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff  <= RadixReset;
         dig_lo_ff <= DigitsLowReset;
         dig_hi_ff <= DigitsHighReset;
      end else if (csr_we) begin
         case (csr_index)
            CsrRadix:      radix_ff  <= csr_wdata[RadixWidth-1:0];
            CsrDigitsLow:  dig_lo_ff <= csr_wdata;
            CsrDigitsHigh: dig_hi_ff <= csr_wdata;
            default:       ;
         endcase
      end
   end

   // classify and convert
   nbe_front u_front (
      .clock  (clock),
      .reset  (reset),
      .push   (req_push),
      .full   (req_full),
      .data   (req_data),
      .radix  (radix_ff),
      .q_push (q_push),
      .q_item (q_in_item),
      .q_full (q_full)
   );

   // decoupling queue
   nbe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_in_item),
      .full      (q_full),
      .pop       (q_pop),
      .head_item (q_head),
      .empty     (q_empty)
   );

   // serialize characters
   nbe_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_item      (q_head),
      .q_empty     (q_empty),
      .q_pop       (q_pop),
      .digit_table ({dig_hi_ff, dig_lo_ff}),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_data    (rsp_data)
   );

endmodule

// File: rtl/core/nbe_checker.sv
module nbe_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_push,
   input logic             req_full,
   input logic             rsp_empty,
   input logic             rsp_pop,
   input nbe_pkg::rsp_type rsp_data
);

   logic seen_ff;

   // any input transaction accepted since reset
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
      end else if (req_push && !req_full) begin
         seen_ff <= 1'b1;
      end
   end

   // output side is empty right after reset
   a_empty_after_reset: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result present right after reset");

   // input side is open right after reset
   a_open_after_reset: assert property (@(posedge clock) reset |=> !req_full)
      else $error("input blocked right after reset");

   // no result without a prior input transaction
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !seen_ff |-> rsp_empty)
      else $error("result with no input accepted");

   // a waiting result holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("waiting result changed");

endmodule

bind nonprintable_byte_escaper_core nbe_checker u_nbe_checker (
   .clock     (clock),
   .reset     (reset),
   .req_push  (req_push),
   .req_full  (req_full),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data)
);
